>>> src/dcdws_pkg.sv
package dcdws_pkg;

    localparam int DEF_MAX_WINDOW = 64;
    localparam int DEF_PRICE_BITS = 32;

    localparam int WL_BITS        = 7;
    localparam int TOL_BITS       = 8;
    localparam int CFG_DATA_BITS  = 8;
    localparam int CFG_INDEX_BITS = 1;

    localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_LENGTH   = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_EQUAL_TOLERANCE = 1'b1;

    localparam logic [WL_BITS-1:0]  WINDOW_LENGTH_RESET   = 7'd6;
    localparam logic [TOL_BITS-1:0] EQUAL_TOLERANCE_RESET = 8'd0;

    typedef struct packed {
        logic valid;
        logic push;
    } bar_ctl_t;

endpackage

>>> src/dcdws_if.sv
interface dcdws_bar_if #(
    parameter int PRICE_BITS = 32
);
    logic                  valid;
    logic                  ready;
    logic [PRICE_BITS-1:0] close_price;
    logic [PRICE_BITS-1:0] high_price;
    logic [PRICE_BITS-1:0] low_price;

    modport source (output valid, output close_price, output high_price,
                    output low_price, input ready);
    modport sink   (input valid, input close_price, input high_price,
                    input low_price, output ready);
endinterface

interface dcdws_sum_if #(
    parameter int SUM_BITS = 39
);
    logic                       valid;
    logic                       ready;
    logic signed [SUM_BITS-1:0] window_sum;
    logic                       window_full;

    modport source (output valid, output window_sum, output window_full, input ready);
    modport sink   (input valid, input window_sum, input window_full, output ready);
endinterface

>>> src/dcdws_bar.sv
module dcdws_bar #(
    parameter int PRICE_BITS = dcdws_pkg::DEF_PRICE_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  logic                         advance,
    input  logic [PRICE_BITS-1:0]        close_price,
    input  logic [PRICE_BITS-1:0]        high_price,
    input  logic [PRICE_BITS-1:0]        low_price,
    input  logic [dcdws_pkg::TOL_BITS-1:0] equal_tolerance,
    output dcdws_pkg::bar_ctl_t          ctl,
    output logic signed [PRICE_BITS:0]   bar_value
);
    import dcdws_pkg::*;

    localparam int CW = (PRICE_BITS > TOL_BITS) ? PRICE_BITS : TOL_BITS;

    logic [PRICE_BITS-1:0]      last_close_reg;
    logic                       seen_reg;
    bar_ctl_t                   ctl_reg;
    logic signed [PRICE_BITS:0] value_reg;

    logic [PRICE_BITS-1:0]      diff;
    logic [PRICE_BITS-1:0]      ref_price;
    logic                       rose;
    logic                       unchanged;
    logic signed [PRICE_BITS:0] value_next;

    always_comb
    begin
        rose      = close_price > last_close_reg;
        diff      = rose ? (close_price - last_close_reg) : (last_close_reg - close_price);
        unchanged = (diff == '0) || (CW'(diff) < CW'(equal_tolerance));
        if (rose)
        begin
            ref_price = (low_price < last_close_reg) ? low_price : last_close_reg;
        end
        else
        begin
            ref_price = (high_price > last_close_reg) ? high_price : last_close_reg;
        end
        if (unchanged)
        begin
            value_next = '0;
        end
        else
        begin
            value_next = $signed({1'b0, close_price}) - $signed({1'b0, ref_price});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_close_reg <= '0;
            seen_reg       <= 1'b0;
            ctl_reg        <= '0;
        end
        else if (accept)
        begin
            last_close_reg <= close_price;
            seen_reg       <= 1'b1;
            ctl_reg.valid  <= 1'b1;
            ctl_reg.push   <= seen_reg;
        end
        else if (advance)
        begin
            ctl_reg.valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            value_reg <= value_next;
        end
    end

    assign ctl       = ctl_reg;
    assign bar_value = value_reg;

endmodule

>>> src/dcdws_cell.sv
module dcdws_cell #(
    parameter int IDX        = 0,
    parameter int VALUE_BITS = 33,
    parameter int LEN_BITS   = 7
) (
    input  logic                         clk,
    input  logic                         shift,
    input  logic signed [VALUE_BITS-1:0] d,
    input  logic [LEN_BITS-1:0]          len_m1,
    output logic signed [VALUE_BITS-1:0] q,
    output logic signed [VALUE_BITS-1:0] tap
);
    logic signed [VALUE_BITS-1:0] value_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            value_reg <= d;
        end
    end

    assign q   = value_reg;
    assign tap = (len_m1 == LEN_BITS'(IDX)) ? value_reg : '0;

endmodule

>>> src/directional_close_diff_window_sum.sv
// Directional close-difference window sum.
// Input channel "bar" carries one price bar per transaction (close, high, low).
// Output channel "result" carries one transaction per bar: the exact sum of
// the most recent window_length bar values and a flag set once the window is
// full. The first bar after reset only records its close and reports an
// empty window.
// Configuration: cfg_we/cfg_index/cfg_data write window_length (index 0,
// empties the window) or equal_tolerance (index 1); write only while idle.
// Pipeline: an accepted bar is registered in the bar stage and then in the
// output register, which drives result.valid. Throughput: one bar per cycle
// while result is taken; the window is a shift chain of MAX_WINDOW cells
// feeding a single running-sum adder; every bar after the first one updates it.
// Reset: clears the pipeline, window count, running sum and first-bar flag;
// registers return to window_length 6, equal_tolerance 0.
// Stall: when result is not taken, the output register holds and bar.ready
// drops once the bar stage is also occupied; nothing is lost.
module directional_close_diff_window_sum #(
    parameter int MAX_WINDOW = dcdws_pkg::DEF_MAX_WINDOW,
    parameter int PRICE_BITS = dcdws_pkg::DEF_PRICE_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [dcdws_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [dcdws_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    dcdws_bar_if.sink                          bar,
    dcdws_sum_if.source                        result
);
    import dcdws_pkg::*;

    localparam int VALUE_BITS = PRICE_BITS + 1;
    localparam int SUM_BITS   = VALUE_BITS + $clog2(MAX_WINDOW);
    localparam int LEN_BITS   = $clog2(MAX_WINDOW + 1);
    localparam int LW         = (LEN_BITS > WL_BITS) ? LEN_BITS : WL_BITS;

    logic [WL_BITS-1:0]  window_length_reg;
    logic [TOL_BITS-1:0] equal_tolerance_reg;

    logic                       advance;
    logic                       accept;
    bar_ctl_t                   ctl;
    logic signed [PRICE_BITS:0] bar_value;

    logic [LW-1:0]       wl_ext;
    logic [LEN_BITS-1:0] len_eff;
    logic [LEN_BITS-1:0] len_m1;

    logic signed [VALUE_BITS-1:0] chain_q   [MAX_WINDOW];
    logic signed [VALUE_BITS-1:0] chain_tap [MAX_WINDOW];
    logic signed [VALUE_BITS-1:0] drop_value;

    logic [LEN_BITS-1:0]        held_reg;
    logic [LEN_BITS-1:0]        held_next;
    logic signed [SUM_BITS-1:0] sum_reg;
    logic signed [SUM_BITS-1:0] sum_next;
    logic                       push;

    logic                       out_valid_reg;
    logic signed [SUM_BITS-1:0] out_sum_reg;
    logic                       out_full_reg;

    assign advance   = !out_valid_reg || result.ready;
    assign bar.ready = !ctl.valid || advance;
    assign accept    = bar.valid && bar.ready;
    assign push      = ctl.valid && ctl.push && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg   <= WINDOW_LENGTH_RESET;
            equal_tolerance_reg <= EQUAL_TOLERANCE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_WINDOW_LENGTH:   window_length_reg   <= cfg_data[WL_BITS-1:0];
                REG_EQUAL_TOLERANCE: equal_tolerance_reg <= cfg_data[TOL_BITS-1:0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        wl_ext = LW'(window_length_reg);
        if (wl_ext == '0)
        begin
            len_eff = LEN_BITS'(1);
        end
        else if (wl_ext > LW'(MAX_WINDOW))
        begin
            len_eff = LEN_BITS'(MAX_WINDOW);
        end
        else
        begin
            len_eff = LEN_BITS'(wl_ext);
        end
        len_m1 = len_eff - LEN_BITS'(1);
    end

    dcdws_bar #(
        .PRICE_BITS (PRICE_BITS)
    ) u_bar (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .advance         (advance),
        .close_price     (bar.close_price),
        .high_price      (bar.high_price),
        .low_price       (bar.low_price),
        .equal_tolerance (equal_tolerance_reg),
        .ctl             (ctl),
        .bar_value       (bar_value)
    );

    for (genvar i = 0; i < MAX_WINDOW; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            dcdws_cell #(
                .IDX        (i),
                .VALUE_BITS (VALUE_BITS),
                .LEN_BITS   (LEN_BITS)
            ) u_cell (
                .clk    (clk),
                .shift  (push),
                .d      (bar_value),
                .len_m1 (len_m1),
                .q      (chain_q[i]),
                .tap    (chain_tap[i])
            );
        end
        else
        begin : g_body
            dcdws_cell #(
                .IDX        (i),
                .VALUE_BITS (VALUE_BITS),
                .LEN_BITS   (LEN_BITS)
            ) u_cell (
                .clk    (clk),
                .shift  (push),
                .d      (chain_q[i-1]),
                .len_m1 (len_m1),
                .q      (chain_q[i]),
                .tap    (chain_tap[i])
            );
        end
    end

    always_comb
    begin
        drop_value = '0;
        for (int i = 0; i < MAX_WINDOW; i++)
        begin
            drop_value = drop_value | chain_tap[i];
        end
    end

    always_comb
    begin
        held_next = held_reg;
        sum_next  = sum_reg;
        if (ctl.push)
        begin
            if (held_reg >= len_eff)
            begin
                held_next = len_eff;
                sum_next  = sum_reg - SUM_BITS'(drop_value) + SUM_BITS'(bar_value);
            end
            else
            begin
                held_next = held_reg + LEN_BITS'(1);
                sum_next  = sum_reg + SUM_BITS'(bar_value);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg      <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == REG_WINDOW_LENGTH)
            begin
                held_reg <= '0;
                sum_reg  <= '0;
            end
            else if (push)
            begin
                held_reg <= held_next;
                sum_reg  <= sum_next;
            end
            if (advance)
            begin
                out_valid_reg <= ctl.valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && ctl.valid)
        begin
            out_sum_reg  <= sum_next;
            out_full_reg <= (held_next == len_eff);
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.window_sum  = out_sum_reg;
    assign result.window_full = out_full_reg;

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
    import dcdws_pkg::*;

    localparam int RANDOM_BARS = 1850;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int RING_DEPTH  = DEF_MAX_WINDOW;
    localparam int SUM_W       = 39;

    typedef enum logic {ROW_BAR, ROW_REG} row_kind_t;

    typedef struct packed {
        row_kind_t                 kind;
        logic [31:0]               close_p;
        logic [31:0]               high_p;
        logic [31:0]               low_p;
        logic [CFG_INDEX_BITS-1:0] reg_idx;
        logic [CFG_DATA_BITS-1:0]  reg_val;
        logic                      typed;
        logic [SUM_W-1:0]          typed_sum;
        logic                      typed_full;
    } dir_row_t;

    typedef struct packed {
        logic [SUM_W-1:0] win_sum;
        logic             full;
    } sum_rec_t;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    dcdws_bar_if #(.PRICE_BITS(DEF_PRICE_BITS)) bar_ch ();
    dcdws_sum_if #(.SUM_BITS(SUM_W))            res_ch ();

    directional_close_diff_window_sum u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .bar       (bar_ch),
        .result    (res_ch)
    );

    // window predictor state
    logic [WL_BITS-1:0]  win_len_reg;
    logic [TOL_BITS-1:0] win_tol_reg;
    logic [31:0]         win_last_close;
    logic                win_seen_first;
    longint              win_ring [RING_DEPTH];
    int unsigned         win_wr_idx;
    int unsigned         win_held;
    longint              win_total;

    sum_rec_t    pending_sums [$];
    sum_rec_t    head_rec;
    dir_row_t    dir_rows [$];
    int          err_count;
    int          cycle_count;
    bit          rx_stalls;
    bit          tx_gaps;
    int unsigned walk_step;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function void window_reset();
        win_len_reg    = WINDOW_LENGTH_RESET;
        win_tol_reg    = EQUAL_TOLERANCE_RESET;
        win_last_close = '0;
        win_seen_first = 1'b0;
        foreach (win_ring[i])
            win_ring[i] = 0;
        win_wr_idx = 0;
        win_held   = 0;
        win_total  = 0;
    endfunction

    function void window_write_reg(logic [CFG_INDEX_BITS-1:0] idx,
                                   logic [CFG_DATA_BITS-1:0] val);
        if (idx == REG_WINDOW_LENGTH)
        begin
            win_len_reg = val[WL_BITS-1:0];
            win_wr_idx  = 0;
            win_held    = 0;
            win_total   = 0;
        end
        else if (idx == REG_EQUAL_TOLERANCE)
        begin
            win_tol_reg = val[TOL_BITS-1:0];
        end
    endfunction

    function sum_rec_t predict_window_sum(logic [31:0] c, logic [31:0] h, logic [31:0] l);
        int unsigned len;
        int unsigned old;
        logic [31:0] p;
        logic [31:0] diff;
        logic [31:0] base_p;
        longint      v;
        sum_rec_t    rec;
        len = (win_len_reg == 0) ? 1 :
              (win_len_reg > RING_DEPTH) ? RING_DEPTH : int'(win_len_reg);
        p = win_last_close;
        if (!win_seen_first)
        begin
            win_seen_first = 1'b1;
        end
        else
        begin
            diff = (c >= p) ? c - p : p - c;
            if (diff == 0 || diff < {24'b0, win_tol_reg})
                v = 0;
            else
            begin
                if (c > p)
                    base_p = (l < p) ? l : p;
                else
                    base_p = (h > p) ? h : p;
                v = $signed({32'b0, c}) - $signed({32'b0, base_p});
            end
            if (win_held >= len)
            begin
                old = (win_wr_idx + RING_DEPTH - len) % RING_DEPTH;
                win_total -= win_ring[old];
                win_held = len;
            end
            else
            begin
                win_held++;
            end
            win_ring[win_wr_idx] = v;
            win_total += v;
            win_wr_idx = (win_wr_idx + 1) % RING_DEPTH;
        end
        win_last_close = c;
        rec.win_sum = win_total[SUM_W-1:0];
        rec.full    = (win_held == len);
        return rec;
    endfunction

    function automatic dir_row_t bar_row(logic [31:0] c, logic [31:0] h, logic [31:0] l);
        return dir_row_t'{ROW_BAR, c, h, l, REG_WINDOW_LENGTH, '0, 1'b0, '0, 1'b0};
    endfunction

    function automatic dir_row_t typed_row(logic [31:0] c, logic [31:0] h, logic [31:0] l,
                                           logic [SUM_W-1:0] s, logic f);
        return dir_row_t'{ROW_BAR, c, h, l, REG_WINDOW_LENGTH, '0, 1'b1, s, f};
    endfunction

    function automatic dir_row_t reg_row(logic [CFG_INDEX_BITS-1:0] idx,
                                         logic [CFG_DATA_BITS-1:0] val);
        return dir_row_t'{ROW_REG, '0, '0, '0, idx, val, 1'b0, '0, 1'b0};
    endfunction

    function void append_row(dir_row_t row);
        dir_rows = {dir_rows, row};
    endfunction

    function void gen_bar(output logic [31:0] c, output logic [31:0] h,
                          output logic [31:0] l);
        int unsigned r;
        logic [31:0] d;
        logic [31:0] p;
        p = win_last_close;
        r = $urandom_range(0, 99);
        d = $urandom_range(0, walk_step);
        if (r < 55)
        begin
            c = $urandom_range(0, 1) ? p + d : p - d;
            h = c + $urandom_range(0, 300);
            l = c - $urandom_range(0, 300);
        end
        else if (r < 65)
        begin
            c = p;
            h = $urandom;
            l = $urandom;
        end
        else if (r < 82)
        begin
            c = $urandom;
            h = $urandom;
            l = $urandom;
        end
        else if (r < 94)
        begin
            c = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
            h = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
            l = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
        end
        else
        begin
            // inconsistent bar: high below close, low above close
            c = $urandom_range(0, 1) ? p + d : p - d;
            h = c - $urandom_range(1, 300);
            l = c + $urandom_range(1, 300);
        end
    endfunction

    task automatic push_bar(logic [31:0] c, logic [31:0] h, logic [31:0] l,
                            logic typed, logic [SUM_W-1:0] ts, logic tf);
        sum_rec_t rec;
        cfg_we             <= 1'b0;
        bar_ch.valid       <= 1'b1;
        bar_ch.close_price <= c;
        bar_ch.high_price  <= h;
        bar_ch.low_price   <= l;
        @(posedge clk);
        while (!bar_ch.ready)
            @(posedge clk);
        rec = predict_window_sum(c, h, l);
        if (typed)
            rec = '{ts, tf};
        pending_sums = {pending_sums, rec};
    endtask

    task automatic hold_bars(int unsigned n);
        if (n > 0)
        begin
            bar_ch.valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        bar_ch.valid <= 1'b0;
        cfg_we       <= 1'b0;
        while (pending_sums.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        window_write_reg(idx, val);
    endtask

    function automatic logic [CFG_DATA_BITS-1:0] pick_length();
        logic [WL_BITS-1:0] wl;
        case ($urandom_range(0, 6))
            0: wl = 0;
            1: wl = 1;
            2: wl = 64;
            3: wl = $urandom_range(65, 127);
            4: wl = $urandom_range(2, 8);
            default: wl = $urandom_range(1, 64);
        endcase
        return {1'($urandom_range(0, 1)), wl};
    endfunction

    function automatic logic [CFG_DATA_BITS-1:0] pick_tolerance();
        case ($urandom_range(0, 3))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'($urandom_range(1, 16));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // check each result transaction against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_sums.size() == 0)
            begin
                $display("%0t unexpected result: exp none, got sum %0d full %0b", $time,
                         res_ch.window_sum, res_ch.window_full);
                err_count++;
            end
            else
            begin
                head_rec = pending_sums.pop_front();
                if (res_ch.window_sum !== head_rec.win_sum)
                begin
                    $display("%0t window_sum mismatch: exp %0d got %0d", $time,
                             $signed(head_rec.win_sum), res_ch.window_sum);
                    err_count++;
                end
                if (res_ch.window_full !== head_rec.full)
                begin
                    $display("%0t window_full mismatch: exp %0b got %0b", $time,
                             head_rec.full, res_ch.window_full);
                    err_count++;
                end
            end
        end
    end

    initial
    begin
        res_ch.ready <= 1'b0;
        do
            @(posedge clk);
        while (!rst_n);
        forever
        begin
            res_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge clk);
            if (rx_stalls)
            begin
                res_ch.ready <= 1'b0;
                repeat (pick_gap()) @(posedge clk);
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: errors");
        $finish;
    end

    initial
    begin
        int unsigned sent;
        int unsigned n;
        logic [31:0] c;
        logic [31:0] h;
        logic [31:0] l;

        err_count          = 0;
        rx_stalls          = 1'b1;
        tx_gaps            = 1'b1;
        walk_step          = 1000;
        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_index          <= '0;
        cfg_data           <= '0;
        bar_ch.valid       <= 1'b0;
        bar_ch.close_price <= '0;
        bar_ch.high_price  <= '0;
        bar_ch.low_price   <= '0;
        window_reset();

        append_row(typed_row(32'd100, 32'd120, 32'd90, '0, 1'b0));
        append_row(typed_row(32'd100, 32'd100, 32'd100, '0, 1'b0));
        append_row(bar_row(32'd150, 32'd160, 32'd80));
        append_row(bar_row(32'd130, 32'd170, 32'd120));
        append_row(bar_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0));
        append_row(bar_row(32'h0, 32'hFFFF_FFFF, 32'h0));
        append_row(bar_row(32'd500, 32'd100, 32'd600));
        append_row(bar_row(32'd300, 32'd100, 32'd900));
        append_row(bar_row(32'd1000, 32'd0, 32'd2000));
        append_row(reg_row(REG_EQUAL_TOLERANCE, 8'd255));
        append_row(bar_row(32'd1254, 32'd1300, 32'd1200));
        append_row(bar_row(32'd1509, 32'd1600, 32'd1000));
        append_row(bar_row(32'd1255, 32'd1600, 32'd1000));
        append_row(reg_row(REG_WINDOW_LENGTH, 8'd0));
        append_row(bar_row(32'd2000, 32'd2100, 32'd1900));
        append_row(bar_row(32'd2000, 32'd2000, 32'd2000));
        append_row(reg_row(REG_EQUAL_TOLERANCE, 8'd0));
        append_row(reg_row(REG_WINDOW_LENGTH, 8'h81));
        append_row(typed_row(32'd2001, 32'd2001, 32'd2001, 39'd1, 1'b1));
        append_row(reg_row(REG_WINDOW_LENGTH, 8'hFF));
        append_row(typed_row(32'hFFFF_FFFF, 32'h0, 32'h0, 39'd4294967295, 1'b0));
        append_row(typed_row(32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 39'd0, 1'b0));
        append_row(reg_row(REG_WINDOW_LENGTH, 8'hC0));
        append_row(bar_row(32'd5, 32'd5, 32'd5));
        append_row(bar_row(32'd4, 32'd9, 32'd1));
        append_row(reg_row(REG_WINDOW_LENGTH, 8'd64));
        append_row(bar_row(32'd7, 32'd8, 32'd2));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_REG)
            begin
                drain_results();
                write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
            end
            else
            begin
                push_bar(dir_rows[i].close_p, dir_rows[i].high_p, dir_rows[i].low_p,
                         dir_rows[i].typed, dir_rows[i].typed_sum, dir_rows[i].typed_full);
                hold_bars(($urandom_range(0, 2) == 0) ? pick_gap() : 0);
            end
        end

        sent = 0;
        while (sent < RANDOM_BARS)
        begin
            drain_results();
            if ($urandom_range(0, 2) != 0)
                write_reg(REG_WINDOW_LENGTH, pick_length());
            if ($urandom_range(0, 1) != 0)
                write_reg(REG_EQUAL_TOLERANCE, pick_tolerance());
            tx_gaps   = ($urandom_range(0, 3) != 0);
            rx_stalls = ($urandom_range(0, 3) != 0);
            walk_step = ($urandom_range(0, 2) == 0) ? 1000 : int'(win_tol_reg) + 4;
            n = $urandom_range(20, 150);
            if (n > RANDOM_BARS - sent)
                n = RANDOM_BARS - sent;
            repeat (n)
            begin
                gen_bar(c, h, l);
                push_bar(c, h, l, 1'b0, '0, 1'b0);
                sent++;
                hold_bars((tx_gaps && $urandom_range(0, 2) == 0) ? pick_gap() : 0);
            end
        end

        bar_ch.valid <= 1'b0;
        while (pending_sums.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (err_count == 0 && pending_sums.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

>>> files.f
src/dcdws_pkg.sv
src/dcdws_if.sv
src/dcdws_bar.sv
src/dcdws_cell.sv
src/directional_close_diff_window_sum.sv
tb/sv/tb.sv
